[hw/rtl/skdc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skdc_pkg
// Shared types, register codes and constants of the soft-knee compressor.
// ----------------------------------------------------------------------------
package skdc_pkg;

    typedef enum logic [2:0] {
        REG_THRESHOLD_DB  = 3'd0,
        REG_SLOPE         = 3'd1,
        REG_KNEE_DB       = 3'd2,
        REG_KNEE_SCALE    = 3'd3,
        REG_ATTACK_COEFF  = 3'd4,
        REG_RELEASE_COEFF = 3'd5,
        REG_MAKEUP_DB     = 3'd6,
        REG_AUTO_MAKEUP   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [14:0] threshold_db;
        logic [15:0]        slope;
        logic [12:0]        knee_db;
        logic [15:0]        knee_scale;
        logic [15:0]        attack_coeff;
        logic [15:0]        release_coeff;
        logic signed [13:0] makeup_db;
        logic               auto_makeup;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_ENV,
        F_LVL,
        F_NORM,
        F_SQR,
        F_DB,
        F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_CLS,
        B_M1,
        B_M2,
        B_NET,
        B_EXP,
        B_MUL,
        B_SHIFT,
        B_OUT
    } back_state_t;

    localparam logic signed [14:0] RST_THRESHOLD_DB  = -15'sd8192;
    localparam logic [15:0]        RST_SLOPE         = 16'd59297;
    localparam logic [12:0]        RST_KNEE_DB       = 13'd1536;
    localparam logic [15:0]        RST_KNEE_SCALE    = 16'd4941;
    localparam logic [15:0]        RST_ATTACK_COEFF  = 16'd291;
    localparam logic [15:0]        RST_RELEASE_COEFF = 16'd29;
    localparam logic signed [13:0] RST_MAKEUP_DB     = 14'sd0;

    localparam logic [31:0]        LEVEL_FLOOR   = 32'd214748;
    localparam logic signed [19:0] DB_PER_OCTAVE = 20'sd394566;
    localparam logic signed [23:0] OCTAVE_PER_DB = 24'sd2786636;
    localparam logic [13:0]        RED_MAX       = 14'd16383;

    // Q1.30 factors 2^(2^-(k+1))
    function automatic logic [30:0] exp2_step(input logic [3:0] k);
        logic [30:0] v;
        case (k)
            4'd0:    v = 31'd1518500250;
            4'd1:    v = 31'd1276901417;
            4'd2:    v = 31'd1170923762;
            4'd3:    v = 31'd1121280436;
            4'd4:    v = 31'd1097253708;
            4'd5:    v = 31'd1085434106;
            4'd6:    v = 31'd1079572136;
            4'd7:    v = 31'd1076653033;
            4'd8:    v = 31'd1075196443;
            4'd9:    v = 31'd1074468888;
            4'd10:   v = 31'd1074105294;
            4'd11:   v = 31'd1073923544;
            4'd12:   v = 31'd1073832680;
            4'd13:   v = 31'd1073787251;
            4'd14:   v = 31'd1073764537;
            default: v = 31'd1073753181;
        endcase
        return v;
    endfunction

    function automatic logic [13:0] sat_red(input logic [47:0] v);
        logic [13:0] r;
        if (v > 48'(RED_MAX))
            r = RED_MAX;
        else
            r = v[13:0];
        return r;
    endfunction

endpackage

[hw/rtl/soft_knee_dynamics_compressor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soft_knee_dynamics_compressor
// Feed-forward soft-knee compressor with per-channel peak envelope.
// ----------------------------------------------------------------------------
// The front end takes the item, updates the envelope, normalizes the level
// (fewer shifts for louder envelopes), runs 16 squaring steps for the log2
// fraction and does the dB scaling and hand-off; the back end computes the
// knee curve and makeup, runs 16 steps of the exp2 multiplier and does the
// gain product, rounding and hand-off. Both halves run concurrently on
// successive items through a two-entry queue, so the slower half sets the
// throughput. Configuration may be written only while no item is in flight.
module soft_knee_dynamics_compressor #(
    parameter int CHANNELS    = 2,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [2:0]                             cfg_index,
    input  logic [15:0]                            cfg_data,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [SAMPLE_BITS-1:0] sample_in, rest zero
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]  s_axis_tdata,
    // [0] channel
    input  logic [0:0]                             s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // [SAMPLE_BITS-1:0] sample_out, [SAMPLE_BITS+13:SAMPLE_BITS] reduction_db
    output logic [((SAMPLE_BITS + 21) / 8) * 8 - 1:0] m_axis_tdata,
    // [0] channel_out
    output logic [0:0]                             m_axis_tuser
);

    localparam int ODW = ((SAMPLE_BITS + 21) / 8) * 8;
    localparam int QW  = SAMPLE_BITS + 18;

    skdc_pkg::cfg_t          cfg_reg;
    skdc_pkg::queue_status_t q_status;

    logic                   f_push_valid, f_push_ready;
    logic                   f_ch, f_neg;
    logic [SAMPLE_BITS-1:0] f_mag;
    logic signed [15:0]     f_level;
    logic                   q_pop_valid, q_pop_ready;
    logic [QW-1:0]          q_pop_data;
    logic                   b_ch;
    logic [SAMPLE_BITS-1:0] b_sample;
    logic [13:0]            b_red;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_db  <= skdc_pkg::RST_THRESHOLD_DB;
            cfg_reg.slope         <= skdc_pkg::RST_SLOPE;
            cfg_reg.knee_db       <= skdc_pkg::RST_KNEE_DB;
            cfg_reg.knee_scale    <= skdc_pkg::RST_KNEE_SCALE;
            cfg_reg.attack_coeff  <= skdc_pkg::RST_ATTACK_COEFF;
            cfg_reg.release_coeff <= skdc_pkg::RST_RELEASE_COEFF;
            cfg_reg.makeup_db     <= skdc_pkg::RST_MAKEUP_DB;
            cfg_reg.auto_makeup   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (skdc_pkg::reg_idx_t'(cfg_index))
                skdc_pkg::REG_THRESHOLD_DB:  cfg_reg.threshold_db  <= cfg_data[14:0];
                skdc_pkg::REG_SLOPE:         cfg_reg.slope         <= cfg_data;
                skdc_pkg::REG_KNEE_DB:       cfg_reg.knee_db       <= cfg_data[12:0];
                skdc_pkg::REG_KNEE_SCALE:    cfg_reg.knee_scale    <= cfg_data;
                skdc_pkg::REG_ATTACK_COEFF:  cfg_reg.attack_coeff  <= cfg_data;
                skdc_pkg::REG_RELEASE_COEFF: cfg_reg.release_coeff <= cfg_data;
                skdc_pkg::REG_MAKEUP_DB:     cfg_reg.makeup_db     <= cfg_data[13:0];
                skdc_pkg::REG_AUTO_MAKEUP:   cfg_reg.auto_makeup   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    skdc_front #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_channel   (s_axis_tuser[0]),
        .in_sample    (s_axis_tdata[SAMPLE_BITS-1:0]),
        .push_valid   (f_push_valid),
        .push_ready   (f_push_ready),
        .push_channel (f_ch),
        .push_neg     (f_neg),
        .push_mag     (f_mag),
        .push_level   (f_level)
    );

    skdc_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_push_valid),
        .push_ready (f_push_ready),
        .push_data  ({f_level, f_mag, f_neg, f_ch}),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data),
        .status     (q_status)
    );

    skdc_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .pop_valid     (q_pop_valid),
        .pop_ready     (q_pop_ready),
        .pop_channel   (q_pop_data[0]),
        .pop_neg       (q_pop_data[1]),
        .pop_mag       (q_pop_data[SAMPLE_BITS+1:2]),
        .pop_level     (q_pop_data[QW-1:SAMPLE_BITS+2]),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_channel   (b_ch),
        .out_sample    (b_sample),
        .out_reduction (b_red)
    );

    assign m_axis_tdata    = ODW'({b_red, b_sample});
    assign m_axis_tuser[0] = b_ch;

    // the front end is busy with each item after accepting it
    a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("front accepted back-to-back items");

    // a result is never followed by another in the next cycle
    a_back_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid)
        else $error("back delivered back-to-back results");

    // a full queue cannot be empty and must hold off the front end
    a_queue_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> (!q_status.empty && !f_push_ready))
        else $error("queue status inconsistent");

endmodule

[hw/rtl/skdc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skdc_front
// Accepts items, updates the channel envelope and converts it to a dB level.
// ----------------------------------------------------------------------------
module skdc_front #(
    parameter int CHANNELS    = 2,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  skdc_pkg::cfg_t         cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   in_channel,
    input  logic [SAMPLE_BITS-1:0] in_sample,
    output logic                   push_valid,
    input  logic                   push_ready,
    output logic                   push_channel,
    output logic                   push_neg,
    output logic [SAMPLE_BITS-1:0] push_mag,
    output logic signed [15:0]     push_level
);

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    skdc_pkg::front_state_t state_reg, state_next;

    logic [31:0]            env_reg [CHANNELS];
    logic                   ch_reg;
    logic                   neg_reg;
    logic [SAMPLE_BITS-1:0] mag_reg;
    logic [31:0]            lvl_reg;
    logic [4:0]             p_reg;
    logic [15:0]            frac_reg;
    logic [3:0]             iter_reg;
    logic signed [15:0]     db_reg;

    logic [CW-1:0]          idx;
    logic [31:0]            target;
    logic [31:0]            env_cur;
    logic                   rising;
    logic [15:0]            coef;
    logic [31:0]            dif;
    logic [47:0]            adj_sum;
    logic [31:0]            adj;
    logic [31:0]            env_new;
    logic [63:0]            sq;
    logic [32:0]            sq_sh;
    logic signed [5:0]      pm;
    logic signed [41:0]     db_prod;
    logic                   in_neg;

    assign idx     = (CHANNELS > 1) ? CW'(ch_reg) : '0;
    assign target  = 32'(mag_reg) << (32 - SAMPLE_BITS);
    assign env_cur = env_reg[idx];
    assign rising  = target > env_cur;
    assign coef    = rising ? cfg.attack_coeff : cfg.release_coeff;
    assign dif     = rising ? (target - env_cur) : (env_cur - target);
    assign adj_sum = 48'(coef) * 48'(dif) + 48'd32768;
    assign adj     = adj_sum[47:16];
    assign env_new = rising ? (env_cur + adj) : (env_cur - adj);

    assign sq      = 64'(lvl_reg) * 64'(lvl_reg);
    assign sq_sh   = sq[63:31];

    assign pm      = $signed({1'b0, p_reg}) - 6'sd31;
    assign db_prod = 42'($signed({pm, frac_reg})) * 42'(skdc_pkg::DB_PER_OCTAVE);

    assign in_neg  = in_sample[SAMPLE_BITS-1];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            skdc_pkg::F_IDLE: if (in_valid) state_next = skdc_pkg::F_ENV;
            skdc_pkg::F_ENV:  state_next = skdc_pkg::F_LVL;
            skdc_pkg::F_LVL:  state_next = skdc_pkg::F_NORM;
            skdc_pkg::F_NORM: if (lvl_reg[31]) state_next = skdc_pkg::F_SQR;
            skdc_pkg::F_SQR:  if (iter_reg == 4'd15) state_next = skdc_pkg::F_DB;
            skdc_pkg::F_DB:   state_next = skdc_pkg::F_PUSH;
            skdc_pkg::F_PUSH: if (push_ready) state_next = skdc_pkg::F_IDLE;
            default:          state_next = skdc_pkg::F_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        push_valid = 1'b0;
        case (state_reg)
            skdc_pkg::F_IDLE: in_ready = 1'b1;
            skdc_pkg::F_PUSH: push_valid = 1'b1;
            default:
            begin
                in_ready   = 1'b0;
                push_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= skdc_pkg::F_IDLE;
            for (int i = 0; i < CHANNELS; i++)
                env_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == skdc_pkg::F_ENV)
                env_reg[idx] <= env_new;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            skdc_pkg::F_IDLE:
            begin
                ch_reg  <= in_channel;
                neg_reg <= in_neg;
                mag_reg <= in_neg ? (SAMPLE_BITS'(0) - in_sample) : in_sample;
            end
            skdc_pkg::F_LVL:
            begin
                lvl_reg  <= env_cur + skdc_pkg::LEVEL_FLOOR;
                p_reg    <= 5'd31;
                iter_reg <= '0;
                frac_reg <= '0;
            end
            skdc_pkg::F_NORM:
            begin
                // the floor keeps the leading one at bit 17 or above
                if (!lvl_reg[31])
                begin
                    lvl_reg <= {lvl_reg[30:0], 1'b0};
                    p_reg   <= p_reg - 5'd1;
                end
            end
            skdc_pkg::F_SQR:
            begin
                iter_reg <= iter_reg + 4'd1;
                if (sq_sh[32])
                begin
                    frac_reg <= {frac_reg[14:0], 1'b1};
                    lvl_reg  <= sq_sh[32:1];
                end
                else
                begin
                    frac_reg <= {frac_reg[14:0], 1'b0};
                    lvl_reg  <= sq_sh[31:0];
                end
            end
            skdc_pkg::F_DB: db_reg <= db_prod[39:24];
            default: ;
        endcase
    end

    assign push_channel = ch_reg;
    assign push_neg     = neg_reg;
    assign push_mag     = mag_reg;
    assign push_level   = db_reg;

endmodule

[hw/rtl/skdc_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skdc_queue
// Two-entry queue between the level front end and the gain back end.
// ----------------------------------------------------------------------------
module skdc_queue #(
    parameter int WIDTH = 42
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push_valid,
    output logic                    push_ready,
    input  logic [WIDTH-1:0]        push_data,
    output logic                    pop_valid,
    input  logic                    pop_ready,
    output logic [WIDTH-1:0]        pop_data,
    output skdc_pkg::queue_status_t status
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready   = count_reg != 2'd2;
    assign pop_valid    = count_reg != 2'd0;
    assign pop_data     = entry_reg[rd_ptr_reg];
    assign do_push      = push_valid && push_ready;
    assign do_pop       = pop_valid && pop_ready;
    assign status.full  = count_reg == 2'd2;
    assign status.empty = count_reg == 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

[hw/rtl/skdc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skdc_back
// Soft-knee gain reduction, makeup, exp2 gain and output saturation.
// ----------------------------------------------------------------------------
module skdc_back #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  skdc_pkg::cfg_t         cfg,
    input  logic                   pop_valid,
    output logic                   pop_ready,
    input  logic                   pop_channel,
    input  logic                   pop_neg,
    input  logic [SAMPLE_BITS-1:0] pop_mag,
    input  logic signed [15:0]     pop_level,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   out_channel,
    output logic [SAMPLE_BITS-1:0] out_sample,
    output logic [13:0]            out_reduction
);

    localparam int PW = SAMPLE_BITS + 31;

    skdc_pkg::back_state_t state_reg, state_next;

    logic                   ch_reg;
    logic                   neg_reg;
    logic [SAMPLE_BITS-1:0] mag_reg;
    logic signed [15:0]     lvl_reg;
    logic                   below_reg;
    logic                   knee_reg;
    logic [15:0]            o_reg;
    logic [31:0]            p1_reg;
    logic [25:0]            kk_reg;
    logic [13:0]            red_reg;
    logic [13:0]            rt_reg;
    logic signed [7:0]      n_reg;
    logic [15:0]            f_reg;
    logic [3:0]             k_reg;
    logic [30:0]            mant_reg;
    logic [PW-1:0]          mprod_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;

    logic signed [17:0] l2, t2, k18, o_knee, o_lin;
    logic [47:0]        knee_sum;
    logic [32:0]        lin_sum;
    logic [47:0]        thr_sum;
    logic signed [16:0] mk, net;
    logic signed [40:0] ef;
    logic [61:0]        mant_sum;
    logic signed [8:0]  rsh;
    logic [63:0]        prod64, rnd, y64, lim64, y;

    assign l2     = {lvl_reg[15], lvl_reg, 1'b0};
    assign t2     = {{2{cfg.threshold_db[14]}}, cfg.threshold_db, 1'b0};
    assign k18    = {5'b0, cfg.knee_db};
    assign o_knee = l2 - t2 + k18;
    assign o_lin  = 18'(lvl_reg) - 18'(cfg.threshold_db);

    assign knee_sum = 48'(p1_reg) * 48'(cfg.knee_scale) + 48'd33554432;
    assign lin_sum  = 33'(p1_reg) + 33'd32768;
    // reduction at the threshold itself sits at the middle of the knee
    assign thr_sum  = 48'(kk_reg) * 48'(cfg.knee_scale) + 48'd33554432;

    assign mk  = cfg.auto_makeup ? $signed({3'b0, rt_reg}) : 17'(cfg.makeup_db);
    assign net = mk - $signed({3'b0, red_reg});
    assign ef  = 41'(net) * 41'(skdc_pkg::OCTAVE_PER_DB);

    assign mant_sum = 62'(mant_reg) * 62'(skdc_pkg::exp2_step(k_reg)) + 62'd536870912;

    assign rsh    = 9'sd30 - 9'(n_reg);
    assign prod64 = 64'(mprod_reg);
    assign rnd    = 64'd1 << (rsh[5:0] - 6'd1);
    assign y64    = (prod64 + rnd) >> rsh[5:0];
    assign lim64  = neg_reg ? (64'd1 << (SAMPLE_BITS - 1))
                            : ((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);

    always_comb
    begin
        if (rsh < 9'sd1)
            y = (prod64 != 64'd0) ? lim64 : 64'd0;
        else if (rsh > 9'sd62)
            y = 64'd0;
        else if (y64 > lim64)
            y = lim64;
        else
            y = y64;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            skdc_pkg::B_IDLE:  if (pop_valid) state_next = skdc_pkg::B_CLS;
            skdc_pkg::B_CLS:   state_next = skdc_pkg::B_M1;
            skdc_pkg::B_M1:    state_next = skdc_pkg::B_M2;
            skdc_pkg::B_M2:    state_next = skdc_pkg::B_NET;
            skdc_pkg::B_NET:   state_next = skdc_pkg::B_EXP;
            skdc_pkg::B_EXP:   if (k_reg == 4'd15) state_next = skdc_pkg::B_MUL;
            skdc_pkg::B_MUL:   state_next = skdc_pkg::B_SHIFT;
            skdc_pkg::B_SHIFT: state_next = skdc_pkg::B_OUT;
            skdc_pkg::B_OUT:   if (out_ready) state_next = skdc_pkg::B_IDLE;
            default:           state_next = skdc_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        pop_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            skdc_pkg::B_IDLE: pop_ready = 1'b1;
            skdc_pkg::B_OUT:  out_valid = 1'b1;
            default:
            begin
                pop_ready = 1'b0;
                out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= skdc_pkg::B_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            skdc_pkg::B_IDLE:
            begin
                ch_reg  <= pop_channel;
                neg_reg <= pop_neg;
                mag_reg <= pop_mag;
                lvl_reg <= pop_level;
            end
            skdc_pkg::B_CLS:
            begin
                below_reg <= l2 < (t2 - k18);
                knee_reg  <= l2 < (t2 + k18);
                o_reg     <= (l2 < (t2 + k18)) ? o_knee[15:0] : o_lin[15:0];
            end
            skdc_pkg::B_M1:
            begin
                p1_reg <= knee_reg ? 32'(o_reg) * 32'(o_reg)
                                   : 32'(o_reg) * 32'(cfg.slope);
                kk_reg <= 26'(cfg.knee_db) * 26'(cfg.knee_db);
            end
            skdc_pkg::B_M2:
            begin
                if (below_reg)
                    red_reg <= '0;
                else if (knee_reg)
                    red_reg <= skdc_pkg::sat_red(48'(knee_sum[47:26]));
                else
                    red_reg <= skdc_pkg::sat_red(48'(lin_sum[32:16]));
                rt_reg <= skdc_pkg::sat_red(48'(thr_sum[47:26]));
            end
            skdc_pkg::B_NET:
            begin
                n_reg    <= ef[39:32];
                f_reg    <= ef[31:16];
                k_reg    <= '0;
                mant_reg <= 31'd1073741824;
            end
            skdc_pkg::B_EXP:
            begin
                k_reg <= k_reg + 4'd1;
                f_reg <= {f_reg[14:0], 1'b0};
                if (f_reg[15])
                    mant_reg <= mant_sum[60:30];
            end
            skdc_pkg::B_MUL:
                mprod_reg <= PW'(mag_reg) * PW'(mant_reg);
            skdc_pkg::B_SHIFT:
                sample_reg <= neg_reg ? SAMPLE_BITS'(64'd0 - y) : SAMPLE_BITS'(y);
            default: ;
        endcase
    end

    assign out_channel   = ch_reg;
    assign out_sample    = sample_reg;
    assign out_reduction = red_reg;

endmodule
